### rtl/lpht_pkg.sv
// Package for the linear probe hash table unit: field widths, command,
// result and slot status codes, and the request/response structs of the modulo unit.
// No dependencies.
package lpht_pkg;

    localparam int KEY_W      = 31;
    localparam int TS_W       = 5;
    localparam int SLOT_OUT_W = 4;
    localparam int RC_W       = 2;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [RC_W-1:0] {
        RC_INSERTED = 2'd0,
        RC_FULL     = 2'd1,
        RC_REMOVED  = 2'd2,
        RC_MISSING  = 2'd3
    } result_code_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_GONE  = 2'd2
    } slot_status_t;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [TS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [TS_W-1:0] remainder;
    } div_rsp_t;

endpackage

### rtl/linear_probe_hash_table_unit.sv
// Linear probe hash table unit: accepts one insert/remove beat, returns one result beat.
// Each request runs the serial modulo, then probes from the home slot, one probe per cycle,
// using 1 .. live table size probes; a new input beat is taken only once the result is emitted.
// Reset: table size 11, all slot status empty, no result pending. Slot keys are not reset.
// Depends on lpht_pkg and lpht_mod_unit.
module linear_probe_hash_table_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration: table size
    input  logic                        cfg_wr_en,
    input  logic [lpht_pkg::TS_W-1:0]   cfg_wr_data,
    // input beat
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,    // [30:0] key, [31] zero
    input  logic [0:0]                  s_tuser,    // [0] cmd
    // result beat
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,    // [3:0] slot, [7:4] zero
    output logic [lpht_pkg::RC_W-1:0]   m_tuser     // [1:0] result_code
);
    import lpht_pkg::*;

    // A 5-bit table size never reaches past slot 30, so only that many slots get storage.
    localparam int MAX_TS     = (1 << TS_W) - 1;
    localparam int USED_SLOTS = (CAPACITY < MAX_TS) ? CAPACITY : MAX_TS;
    localparam int SLOT_W     = $clog2(USED_SLOTS);
    localparam int N_W        = $clog2(USED_SLOTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODULO,
        S_PROBE,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    logic [TS_W-1:0]        table_size_reg;
    cmd_t                   cmd_reg;
    logic [KEY_W-1:0]       key_reg;

    // probe pipeline: read stage addresses the key store, check stage compares
    logic [SLOT_W-1:0]      rd_addr_reg;
    logic [N_W-1:0]         issue_cnt_reg;
    logic [SLOT_W-1:0]      chk_addr_reg;
    logic                   chk_valid_reg;
    logic                   chk_last_reg;
    logic [KEY_W-1:0]       key_q_reg;

    slot_status_t           status_reg [USED_SLOTS];
    logic [KEY_W-1:0]       slot_keys  [USED_SLOTS];

    result_code_t           rc_reg;
    logic [SLOT_OUT_W-1:0]  res_slot_reg;
    logic                   m_tvalid_reg;
    result_code_t           m_rc_reg;
    logic [SLOT_OUT_W-1:0]  m_slot_reg;

    logic [N_W-1:0]         n_live;
    logic                   accept;
    logic                   hit;
    logic                   key_wr_en;
    slot_status_t           chk_status;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    // Live size: zero behaves as one, anything past the storage saturates.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            n_live = N_W'(1);
        end
        else if ({1'b0, table_size_reg} > (TS_W + 1)'(USED_SLOTS))
        begin
            n_live = N_W'(USED_SLOTS);
        end
        else
        begin
            n_live = N_W'(table_size_reg);
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign div_req.start    = accept;
    assign div_req.dividend = s_tdata[KEY_W-1:0];
    assign div_req.divisor  = TS_W'(n_live);

    lpht_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Insert takes any slot not in use; remove needs an occupied slot holding the key.
    assign chk_status = status_reg[chk_addr_reg];
    always_comb
    begin
        if (cmd_reg == CMD_INSERT)
        begin
            hit = (chk_status != ST_USED);
        end
        else
        begin
            hit = (chk_status == ST_USED) && (key_q_reg == key_reg);
        end
    end

    assign key_wr_en = (state_reg == S_PROBE) && chk_valid_reg && hit &&
                       (cmd_reg == CMD_INSERT);

    // Key store: one write port at the check address, one registered read port.
    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            slot_keys[chk_addr_reg] <= key_reg;
        end
        key_q_reg <= slot_keys[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= TS_W'(11);
            cmd_reg        <= CMD_INSERT;
            key_reg        <= '0;
            rd_addr_reg    <= '0;
            issue_cnt_reg  <= '0;
            chk_addr_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            chk_last_reg   <= 1'b0;
            rc_reg         <= RC_INSERTED;
            res_slot_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
            m_rc_reg       <= RC_INSERTED;
            m_slot_reg     <= '0;
            for (int i = 0; i < USED_SLOTS; i++)
            begin
                status_reg[i] <= ST_EMPTY;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                table_size_reg <= cfg_wr_data;
            end

            // drop the result beat once taken, unless a new one replaces it
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= cmd_t'(s_tuser[0]);
                        key_reg   <= s_tdata[KEY_W-1:0];
                        state_reg <= S_MODULO;
                    end
                end

                S_MODULO:
                begin
                    // start probing at the home slot
                    if (div_rsp.done)
                    begin
                        rd_addr_reg   <= SLOT_W'(div_rsp.remainder);
                        issue_cnt_reg <= '0;
                        chk_valid_reg <= 1'b0;
                        state_reg     <= S_PROBE;
                    end
                end

                S_PROBE:
                begin
                    if (chk_valid_reg && (hit || chk_last_reg))
                    begin
                        chk_valid_reg <= 1'b0;
                        state_reg     <= S_EMIT;
                        if (hit)
                        begin
                            status_reg[chk_addr_reg] <= (cmd_reg == CMD_INSERT) ?
                                                        ST_USED : ST_GONE;
                            rc_reg       <= (cmd_reg == CMD_INSERT) ? RC_INSERTED : RC_REMOVED;
                            res_slot_reg <= SLOT_OUT_W'(chk_addr_reg);
                        end
                        else
                        begin
                            rc_reg       <= (cmd_reg == CMD_INSERT) ? RC_FULL : RC_MISSING;
                            res_slot_reg <= '0;
                        end
                    end
                    else if (issue_cnt_reg < n_live)
                    begin
                        // advance the read stage, wrapping at the live size
                        chk_addr_reg  <= rd_addr_reg;
                        chk_valid_reg <= 1'b1;
                        chk_last_reg  <= (issue_cnt_reg == n_live - 1'b1);
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        if (N_W'(rd_addr_reg) == n_live - 1'b1)
                        begin
                            rd_addr_reg <= '0;
                        end
                        else
                        begin
                            rd_addr_reg <= rd_addr_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        chk_valid_reg <= 1'b0;
                    end
                end

                S_EMIT:
                begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_rc_reg     <= rc_reg;
                        m_slot_reg   <= res_slot_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(8 - SLOT_OUT_W){1'b0}}, m_slot_reg};
    assign m_tuser  = m_rc_reg;

endmodule

### rtl/lpht_mod_unit.sv
// Serial restoring modulo unit: key mod table size, two dividend bits per cycle.
// Depends on lpht_pkg.
module lpht_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  lpht_pkg::div_req_t req,
    output lpht_pkg::div_rsp_t rsp
);
    import lpht_pkg::*;

    localparam int SH_W  = KEY_W + 1;
    localparam int STEPS = SH_W / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [SH_W-1:0]  shift_reg;
    logic [TS_W-1:0]  divisor_reg;
    logic [TS_W-1:0]  rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [TS_W-1:0]  rem_one;
    logic [TS_W-1:0]  rem_two;

    // one restoring step: shift in a bit, subtract the divisor if it fits
    function automatic logic [TS_W-1:0] rem_step(input logic [TS_W-1:0] r,
                                                 input logic b,
                                                 input logic [TS_W-1:0] d);
        logic [TS_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[TS_W-1:0];
    endfunction

    assign rem_one = rem_step(rem_reg, shift_reg[SH_W-1], divisor_reg);
    assign rem_two = rem_step(rem_one, shift_reg[SH_W-2], divisor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '0;
            divisor_reg <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                shift_reg   <= {1'b0, req.dividend};
                divisor_reg <= req.divisor;
                rem_reg     <= '0;
                cnt_reg     <= '0;
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_two;
                shift_reg <= {shift_reg[SH_W-3:0], 2'b00};
                cnt_reg   <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for linear_probe_hash_table_unit: random insert/remove traffic over several
// table sizes, checked against a behavioral probe table in a small scoreboard class.
// Depends on lpht_pkg and the RTL of the unit.

import lpht_pkg::*;

typedef struct packed {
    result_code_t              code;
    logic [SLOT_OUT_W-1:0]     slot;
} probe_outcome_t;

class probe_table_board;
    localparam int SLOTS = 16;

    logic [KEY_W-1:0]  slot_key [SLOTS];
    slot_status_t      slot_state [SLOTS];
    logic [TS_W-1:0]   size_reg;
    probe_outcome_t    awaited [$];
    int                errors;

    function new();
        size_reg = TS_W'(11);
        errors   = 0;
        for (int j = 0; j < SLOTS; j++)
        begin
            slot_key[j]   = '0;
            slot_state[j] = ST_EMPTY;
        end
    endfunction

    function void set_size(logic [TS_W-1:0] v);
        size_reg = v;
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    // Walk the probe sequence for one request, update the table, queue the outcome.
    function void note_request(cmd_t op, logic [KEY_W-1:0] k);
        int unsigned    span;
        int unsigned    home;
        int unsigned    s;
        bit             done;
        probe_outcome_t r;
        span = (size_reg == 0) ? 1 : ((size_reg > SLOTS) ? SLOTS : size_reg);
        home = k % span;
        r.code = (op == CMD_INSERT) ? RC_FULL : RC_MISSING;
        r.slot = '0;
        done = 1'b0;
        for (int unsigned i = 0; i < span && !done; i++)
        begin
            s = (home + i) % span;
            if (op == CMD_INSERT)
            begin
                if (slot_state[s] != ST_USED)
                begin
                    slot_key[s]   = k;
                    slot_state[s] = ST_USED;
                    r.code = RC_INSERTED;
                    r.slot = s[SLOT_OUT_W-1:0];
                    done = 1'b1;
                end
            end
            else if (slot_state[s] == ST_USED && slot_key[s] == k)
            begin
                slot_state[s] = ST_GONE;
                r.code = RC_REMOVED;
                r.slot = s[SLOT_OUT_W-1:0];
                done = 1'b1;
            end
        end
        awaited.push_back(r);
    endfunction

    function void check_response(logic [RC_W-1:0] code, logic [SLOT_OUT_W-1:0] slot);
        probe_outcome_t e;
        if (awaited.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result beat: code %0d slot %0d", code, slot);
            return;
        end
        e = awaited.pop_front();
        if (code !== e.code || slot !== e.slot)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected code %0d slot %0d, got code %0d slot %0d",
                         e.code, e.slot, code, slot);
        end
    endfunction
endclass

module testbench;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int SETTLE_CYCLES  = 8;    // block is idle again right after its result beat
    localparam int TAIL_CYCLES    = 60;   // margin past the worst-case latency of one request
    localparam int WATCHDOG_LIMIT = 4000; // far beyond gap + latency + receiver stall
    localparam int KEY_POOL_MAX   = 64;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [TS_W-1:0]         cfg_wr_data = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [31:0]             s_tdata = '0;      // [30:0] key, [31] zero
    logic [0:0]              s_tuser = '0;      // [0] cmd
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [7:0]              m_tdata;           // [3:0] slot, [7:4] zero
    logic [RC_W-1:0]         m_tuser;           // [1:0] result_code

    probe_table_board        board = new();
    logic [KEY_W-1:0]        key_pool [$];      // keys we inserted, used to aim removes
    int                      burst_left = 0;
    int                      ready_run = 0;
    int                      idle_cycles = 0;
    int                      items_sent = 0;

    linear_probe_hash_table_unit #(.CAPACITY(16)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #HALF_PERIOD clk = ~clk;

    // Receiver: alternate runs of ready and stall with random lengths; now and then
    // hold ready for a long open stretch so results drain without stalls.
    always @(posedge clk)
    begin
        if (ready_run > 0)
        begin
            ready_run <= ready_run - 1;
        end
        else
        begin
            case ($urandom_range(0, 7))
                0:       begin m_tready <= 1'b1; ready_run <= $urandom_range(100, 400); end
                1, 2, 3: begin m_tready <= 1'b0; ready_run <= $urandom_range(0, 30);   end
                default: begin m_tready <= 1'b1; ready_run <= $urandom_range(0, 20);   end
            endcase
        end
    end

    // Check every result beat against the oldest outcome still waiting.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            board.check_response(m_tuser, m_tdata[SLOT_OUT_W-1:0]);
    end

    // Watchdog: end the run when nothing moves on either side for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one request beat and hold it until accepted. Bursts of random length
    // alternate with random gaps; a gap of zero keeps tvalid high across bursts.
    task automatic send_request(cmd_t op, logic [KEY_W-1:0] k);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, k};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        board.note_request(op, k);
        burst_left--;
        items_sent++;
        if (op == CMD_INSERT)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > KEY_POOL_MAX)
                void'(key_pool.pop_front());
        end
    endtask

    // Drop tvalid, let every outstanding result drain, then let the block settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the table size while the block is idle.
    task automatic set_table_size(logic [TS_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        board.set_size(v);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly small keys so home slots collide and duplicates appear; some full-width
    // keys to toggle every key bit; some reuse of keys already inserted.
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1:    return KEY_W'($urandom());
            2, 3:    return (key_pool.size() != 0)
                            ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                            : KEY_W'($urandom_range(0, 63));
            default: return KEY_W'($urandom_range(0, 63));
        endcase
    endfunction

    initial
    begin
        int           batch;
        int unsigned  insert_pct;
        logic [TS_W-1:0] size_pick;
        logic [KEY_W-1:0] k;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset size of eleven, key extremes, duplicates, missing keys,
        // and a collision on home slot zero.
        send_request(CMD_INSERT, KEY_W'(0));
        send_request(CMD_INSERT, {KEY_W{1'b1}});
        send_request(CMD_INSERT, {KEY_W{1'b1}});
        send_request(CMD_REMOVE, {KEY_W{1'b1}});
        send_request(CMD_REMOVE, {KEY_W{1'b1}});
        send_request(CMD_REMOVE, {KEY_W{1'b1}});
        send_request(CMD_REMOVE, KEY_W'(11));
        send_request(CMD_INSERT, KEY_W'(11));
        send_request(CMD_INSERT, KEY_W'(22));

        // Size zero behaves as one: full table, remove, reuse of a deleted slot.
        set_table_size(TS_W'(0));
        send_request(CMD_INSERT, KEY_W'(5));
        send_request(CMD_REMOVE, KEY_W'(0));
        send_request(CMD_INSERT, KEY_W'(5));
        send_request(CMD_INSERT, KEY_W'(6));

        // Oversized register saturates to sixteen; probe wraps past the last slot.
        set_table_size({TS_W{1'b1}});
        send_request(CMD_INSERT, KEY_W'(15));
        send_request(CMD_INSERT, KEY_W'(31));
        send_request(CMD_REMOVE, KEY_W'(31));
        send_request(CMD_REMOVE, KEY_W'(15));

        // Shrink then regrow: slots past the size keep their keys.
        set_table_size(TS_W'(2));
        send_request(CMD_REMOVE, KEY_W'(22));
        send_request(CMD_INSERT, KEY_W'(3));
        set_table_size(TS_W'(16));
        send_request(CMD_REMOVE, KEY_W'(22));

        // Random phases: pick a size, then a batch with a phase-specific insert bias.
        while (items_sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       size_pick = TS_W'(0);
                1:       size_pick = TS_W'(1);
                2:       size_pick = TS_W'(16);
                3:       size_pick = TS_W'($urandom_range(17, 31));
                default: size_pick = TS_W'($urandom_range(2, 15));
            endcase
            set_table_size(size_pick);
            insert_pct = $urandom_range(30, 85);
            batch = $urandom_range(20, 60);
            repeat (batch)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                begin
                    send_request(CMD_INSERT, pick_key());
                end
                else
                begin
                    // Aim most removes at keys that are likely present.
                    if (key_pool.size() != 0 && $urandom_range(0, 9) < 7)
                        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    else
                        k = pick_key();
                    send_request(CMD_REMOVE, k);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            if (board.pending() != 0)
                $display("%0d expected results never arrived", board.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
